// ===== hdl/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants for the capsule point clearance block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned LenW     = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SqrtSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_X    = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_START_Z    = 3'd2,
    CFG_DIR_X      = 3'd3,
    CFG_DIR_Y      = 3'd4,
    CFG_DIR_Z      = 3'd5,
    CFG_SEG_LENGTH = 3'd6,
    CFG_RADIUS     = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== hdl/capsule_point_clearance.sv =====
// ----------------------------------------------------------------------------
// capsule_point_clearance
// Signed clearance of a 3-D point to a capsule, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one query point request per clock cycle while in_ready_o
// is high and returns the capsule radius minus the point's distance to the
// core segment (Q16.16, saturated low at -2^31) with an inside flag. The pipe
// is 41 register stages deep, so it can take a new request before the earlier
// ones reach the result register.
// The stages are eight arithmetic stages (difference,
// projection products, projection sum, clamp, offset products, error and
// magnitude, squares, sum of squares) followed by a 32-stage square root
// pipeline that retires one root bit per stage, then the output stage. The
// whole pipe moves under a single enable, so a stall on the result side
// holds every stage and loses nothing. The segment registers are written
// through the configuration channel, which is always ready; they must only
// be changed while no request is in flight.
`default_nettype none

module capsule_point_clearance
  import cpc_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write channel
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [CoordW-1:0]         cfg_data_i,
  // point request channel
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic signed [CoordW-1:0]  point_x_i,
  input  wire logic signed [CoordW-1:0]  point_y_i,
  input  wire logic signed [CoordW-1:0]  point_z_i,
  // result channel
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic signed [CoordW-1:0]  clearance_o,
  output      logic                      inside_res_o
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] start_q [3];
  logic signed [CoordW-1:0] dir_q   [3];
  logic        [LenW-1:0]   len_q;
  logic        [LenW-1:0]   radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= '0;
        dir_q[i]   <= '0;
      end
      len_q    <= '0;
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_X:    start_q[0] <= cfg_data_i;
        CFG_START_Y:    start_q[1] <= cfg_data_i;
        CFG_START_Z:    start_q[2] <= cfg_data_i;
        CFG_DIR_X:      dir_q[0]   <= cfg_data_i;
        CFG_DIR_Y:      dir_q[1]   <= cfg_data_i;
        CFG_DIR_Z:      dir_q[2]   <= cfg_data_i;
        CFG_SEG_LENGTH: len_q      <= cfg_data_i[LenW-1:0];
        CFG_RADIUS:     radius_q   <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: one enable for every stage, the result register is last
  // ---------------------------------------------------------------------------
  logic en;
  assign en         = out_ready_i | ~out_valid_o;
  assign in_ready_o = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, vout_q;

  // stage 1: offset from the segment start, exact in 33 bits
  logic signed [CoordW:0] d1_q [3];
  logic signed [CoordW-1:0] pt [3];
  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= {pt[i][CoordW-1], pt[i]} - {start_q[i][CoordW-1], start_q[i]};
      end
    end
  end

  // stage 2: projection products d * dir, Q16.16 x Q2.30
  logic signed [2*CoordW:0] p2_q [3];
  logic signed [CoordW:0]   d2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_q[i] <= d1_q[i] * dir_q[i];
        d2_q[i] <= d1_q[i];
      end
    end
  end

  // stage 3: exact sum of the products
  logic signed [2*CoordW+2:0] s3_q;
  logic signed [CoordW:0]     d3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= {{2{p2_q[0][2*CoordW]}}, p2_q[0]}
            + {{2{p2_q[1][2*CoordW]}}, p2_q[1]}
            + {{2{p2_q[2][2*CoordW]}}, p2_q[2]};
      for (int i = 0; i < 3; i++) d3_q[i] <= d2_q[i];
    end
  end

  // stage 4: floor to Q16.16 and clamp to [0, length]
  logic signed [CoordW+4:0] t4;
  logic        [LenW-1:0]   tc4;
  logic        [LenW-1:0]   tc4_q;
  logic signed [CoordW:0]   d4_q [3];

  assign t4 = s3_q[2*CoordW+2:30];

  always_comb begin
    priority if (t4 <= 0) begin
      tc4 = '0;
    end else if (t4 >= $signed({6'd0, len_q})) begin
      tc4 = len_q;
    end else begin
      tc4 = t4[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tc4_q <= tc4;
      for (int i = 0; i < 3; i++) d4_q[i] <= d3_q[i];
    end
  end

  // stage 5: closest point offset products tc * dir
  logic signed [2*CoordW-1:0] m5_q [3];
  logic signed [CoordW:0]     d5_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m5_q[i] <= $signed({1'b0, tc4_q}) * dir_q[i];
        d5_q[i] <= d4_q[i];
      end
    end
  end

  // stage 6: round offset to nearest, error and its magnitude
  logic signed [2*CoordW-1:0] mr6 [3];
  logic signed [CoordW+1:0]   off6 [3];
  logic signed [CoordW+2:0]   e6 [3];
  logic        [CoordW+2:0]   a6 [3];
  logic        [CoordW-1:0]   a6_q [3];
  logic                       far6_q;
  logic                       far6;

  always_comb begin
    far6 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mr6[i]  = m5_q[i] + (64'sd1 <<< 29);
      off6[i] = mr6[i][2*CoordW-1:30];
      e6[i]   = {{2{d5_q[i][CoordW]}}, d5_q[i]} - {off6[i][CoordW+1], off6[i]};
      a6[i]   = e6[i][CoordW+2] ? CoordW'(35'd0) - e6[i] : e6[i];
      if (a6[i][CoordW+2:CoordW] != '0) far6 = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) a6_q[i] <= a6[i][CoordW-1:0];
      far6_q <= far6;
    end
  end

  // stage 7: squares of the error components
  logic [2*CoordW-1:0] q7_q [3];
  logic                far7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) q7_q[i] <= a6_q[i] * a6_q[i];
      far7_q <= far6_q;
    end
  end

  // stage 8: squared distance, far when it leaves 64 bits
  logic [2*CoordW+1:0] sum8;
  logic [2*CoordW-1:0] n8_q;
  logic                far8_q;

  assign sum8 = {2'b00, q7_q[0]} + {2'b00, q7_q[1]} + {2'b00, q7_q[2]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      n8_q   <= sum8[2*CoordW-1:0];
      far8_q <= far7_q | (sum8[2*CoordW+1:2*CoordW] != 2'b00);
    end
  end

  // ---------------------------------------------------------------------------
  // square root: restoring, one root bit per stage
  // ---------------------------------------------------------------------------
  logic [2*CoordW-1:0] rn_q   [1:SqrtSteps];
  logic [CoordW+2:0]   rem_q  [1:SqrtSteps];
  logic [CoordW-1:0]   root_q [1:SqrtSteps];
  logic                rfar_q [1:SqrtSteps];
  logic                rv_q   [1:SqrtSteps];

  logic [2*CoordW-1:0] rn_c   [SqrtSteps];
  logic [CoordW+2:0]   rem_c  [SqrtSteps];
  logic [CoordW-1:0]   root_c [SqrtSteps];
  logic                rfar_c [SqrtSteps];
  logic                rv_c   [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [CoordW+2:0] rem_sh;
    logic [CoordW+2:0] trial;

    if (k == 0) begin : g_first
      assign rn_c[k]   = n8_q;
      assign rem_c[k]  = '0;
      assign root_c[k] = '0;
      assign rfar_c[k] = far8_q;
      assign rv_c[k]   = v8_q;
    end else begin : g_rest
      assign rn_c[k]   = rn_q[k];
      assign rem_c[k]  = rem_q[k];
      assign root_c[k] = root_q[k];
      assign rfar_c[k] = rfar_q[k];
      assign rv_c[k]   = rv_q[k];
    end

    assign rem_sh = {rem_c[k][CoordW:0], rn_c[k][2*CoordW-1:2*CoordW-2]};
    assign trial  = {1'b0, root_c[k], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k+1] <= 1'b0;
      end else if (en) begin
        rv_q[k+1] <= rv_c[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rn_q[k+1]   <= {rn_c[k][2*CoordW-3:0], 2'b00};
        rfar_q[k+1] <= rfar_c[k];
        if (rem_sh >= trial) begin
          rem_q[k+1]  <= rem_sh - trial;
          root_q[k+1] <= {root_c[k][CoordW-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= rem_sh;
          root_q[k+1] <= {root_c[k][CoordW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: radius minus distance, saturated low
  // ---------------------------------------------------------------------------
  logic signed [CoordW+1:0] clr;
  logic signed [CoordW-1:0] clr_sat;
  logic signed [CoordW-1:0] clr_q;

  assign clr = $signed({3'b000, radius_q}) - $signed({2'b00, root_q[SqrtSteps]});

  always_comb begin
    if (rfar_q[SqrtSteps] || (clr[CoordW+1:CoordW-1] != 3'b000
                              && clr[CoordW+1:CoordW-1] != 3'b111)) begin
      clr_sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      clr_sat = clr[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) clr_q <= clr_sat;
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      vout_q <= rv_q[SqrtSteps];
    end
  end

  assign out_valid_o  = vout_q;
  assign clearance_o  = clr_q;
  assign inside_res_o = ~clr_q[CoordW-1];

endmodule

`default_nettype wire
